>>> src/wswh_pkg.sv
// Shared types, Q32 constants and coefficient tables for the wind-sea wave height pipeline.
// No dependencies; used by wswh_mul, wswh_exp and wind_sea_wave_height in src.
package wswh_pkg;

   localparam int HEIGHT_FRAC_BITS = 16;

   typedef logic signed [63:0] q32_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DOMAIN = 2'd1,
      STATUS_SAT    = 2'd2
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] wind_speed;
      logic [23:0] fetch_metres;
      logic [23:0] wind_duration;
   } req_type;

   typedef struct packed {
      logic [23:0] wave_height;
      status_type  status;
   } rsp_type;

   localparam logic [63:0] TWO32 = 64'd4294967296;
   localparam logic [63:0] TWO36 = 64'd68719476736;
   localparam logic [23:0] HMAX = 24'hFFFFFF;

   localparam q32_type LN2_Q32     = 64'sh0000_0000_B172_17F8;
   localparam q32_type LOG2E_Q32   = 64'sh0000_0001_7154_7653;
   localparam q32_type LN10_Q32    = 64'sh0000_0002_4D76_3777;
   localparam q32_type LOG10_2_Q32 = 64'sh0000_0000_4D10_4D42;
   localparam q32_type THREE_LN10  = 3 * LN10_Q32;

   localparam logic [63:0] KNOT_K = (64'd1000000 * TWO32 + 64'd514444 / 2) / 64'd514444;

   localparam q32_type C_FETCH_S = q32_type'((64'd11031 * TWO32 + 64'd10000 / 2) / 64'd10000);
   localparam q32_type C_FETCH_K = q32_type'((64'd45285 * TWO32 + 64'd10000 / 2) / 64'd10000);
   localparam q32_type C_DUR_S   = q32_type'((64'd628 * TWO32 + 64'd1000 / 2) / 64'd1000);
   localparam q32_type C_DUR_K   = q32_type'((64'd16685 * TWO32 + 64'd10000 / 2) / 64'd10000);

   localparam q32_type FA0 =  q32_type'((64'd9969 * TWO32 + 64'd1000000000000 / 2)
                                        / 64'd1000000000000);
   localparam q32_type FA1 = -q32_type'((64'd4801 * TWO32 + 64'd10000000000 / 2)
                                        / 64'd10000000000);
   localparam q32_type FA2 = -q32_type'((64'd4358 * TWO32 + 64'd100000000 / 2) / 64'd100000000);
   localparam q32_type FA3 =  q32_type'((64'd332 * TWO32 + 64'd100000 / 2) / 64'd100000);
   localparam q32_type FA4 = -q32_type'((64'd7028 * TWO32 + 64'd100000 / 2) / 64'd100000);

   localparam q32_type FB0 = -q32_type'((64'd1605 * TWO32 + 64'd10000000000 / 2)
                                        / 64'd10000000000);
   localparam q32_type FB1 =  q32_type'((64'd2031 * TWO32 + 64'd100000000 / 2) / 64'd100000000);
   localparam q32_type FB2 = -q32_type'((64'd8589 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type FB3 =  q32_type'((64'd1306 * TWO32 + 64'd100000 / 2) / 64'd100000);
   localparam q32_type FB4 =  q32_type'((64'd4543 * TWO32 + 64'd10000 / 2) / 64'd10000);

   localparam q32_type DA0 =  q32_type'((64'd1054 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DA1 = -q32_type'((64'd59951 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DA2 =  q32_type'((64'd59858 * TWO32 + 64'd1000000 / 2) / 64'd1000000);

   localparam q32_type DB0 = -q32_type'((64'd1056 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DB1 =  q32_type'((64'd86278 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DB2 = -q32_type'((64'd14444 * TWO32 + 64'd100000 / 2) / 64'd100000);

   localparam q32_type DC0 =  q32_type'((64'd29153 * TWO32 + 64'd1000000000 / 2)
                                        / 64'd1000000000);
   localparam q32_type DC1 = -q32_type'((64'd18225 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DC2 =  q32_type'((64'd3781 * TWO32 + 64'd100000 / 2) / 64'd100000);
   localparam q32_type DC3 = -q32_type'((64'd26859 * TWO32 + 64'd100000 / 2) / 64'd100000);

   localparam q32_type DD0 =  q32_type'((64'd1088 * TWO32 + 64'd1000000000 / 2) / 64'd1000000000);
   localparam q32_type DD1 =  q32_type'((64'd63899 * TWO32 + 64'd1000000000 / 2)
                                        / 64'd1000000000);
   localparam q32_type DD2 = -q32_type'((64'd12567 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DD3 =  q32_type'((64'd79206 * TWO32 + 64'd10000000 / 2) / 64'd10000000);
   localparam q32_type DD4 =  q32_type'((64'd59191 * TWO32 + 64'd100000 / 2) / 64'd100000);

   localparam q32_type QZ = 64'sd0;

   // Four quartic lanes in speed; shorter polynomials lead with zeros.
   localparam q32_type COEF_FETCH [4][5] = '{
      '{QZ, QZ, QZ, QZ, QZ},
      '{QZ, QZ, QZ, QZ, QZ},
      '{FA0, FA1, FA2, FA3, FA4},
      '{FB0, FB1, FB2, FB3, FB4}
   };
   localparam q32_type COEF_DUR [4][5] = '{
      '{QZ, QZ, DA0, DA1, DA2},
      '{QZ, QZ, DB0, DB1, DB2},
      '{QZ, DC0, DC1, DC2, DC3},
      '{DD0, DD1, DD2, DD3, DD4}
   };

   // Ceiling reciprocals of 1..14 at 2^36 for the Taylor term divides.
   localparam logic [36:0] RECIP [1:14] = '{
      37'((TWO36 + 64'd0) / 64'd1),   37'((TWO36 + 64'd1) / 64'd2),
      37'((TWO36 + 64'd2) / 64'd3),   37'((TWO36 + 64'd3) / 64'd4),
      37'((TWO36 + 64'd4) / 64'd5),   37'((TWO36 + 64'd5) / 64'd6),
      37'((TWO36 + 64'd6) / 64'd7),   37'((TWO36 + 64'd7) / 64'd8),
      37'((TWO36 + 64'd8) / 64'd9),   37'((TWO36 + 64'd9) / 64'd10),
      37'((TWO36 + 64'd10) / 64'd11), 37'((TWO36 + 64'd11) / 64'd12),
      37'((TWO36 + 64'd12) / 64'd13), 37'((TWO36 + 64'd13) / 64'd14)
   };

endpackage

>>> src/wswh_dly.sv
// Fixed-depth register delay line for pipeline payload alignment.
// No dependencies.
module wswh_dly #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

>>> src/wswh_mul.sv
// Two-stage signed Q32 multiply: rounded, magnitude saturated at 2^60.
// Depends on wswh_pkg.
module wswh_mul (
   input  logic              clock,
   input  wswh_pkg::q32_type op_a,
   input  wswh_pkg::q32_type op_b,
   output wswh_pkg::q32_type product
);

   logic [63:0] ua, ub;
   logic        neg_ff;
   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0] sum_in, mag_in;
   logic        sat_in;
   wswh_pkg::q32_type product_ff;

   assign ua = op_a[63] ? 64'd0 - 64'(op_a) : 64'(op_a);
   assign ub = op_b[63] ? 64'd0 - 64'(op_b) : 64'(op_b);

   always_ff @(posedge clock) begin
      neg_ff <= op_a[63] ^ op_b[63];
      ll_ff  <= 64'(ua[31:0]) * 64'(ub[31:0]);
      lh_ff  <= 64'(ua[31:0]) * 64'(ub[63:32]);
      hl_ff  <= 64'(ua[63:32]) * 64'(ub[31:0]);
      hh_ff  <= 64'(ua[63:32]) * 64'(ub[63:32]);
   end

   always_comb begin
      sat_in = (hh_ff >= 64'd268435456) || (lh_ff >= 64'h2000_0000_0000_0000)
               || (hl_ff >= 64'h2000_0000_0000_0000);
      sum_in = {hh_ff[31:0], 32'd0} + lh_ff + hl_ff + {32'd0, ll_ff[63:32]}
               + {63'd0, ll_ff[31]};
      mag_in = (sat_in || sum_in > 64'h1000_0000_0000_0000) ? 64'h1000_0000_0000_0000 : sum_in;
   end

   always_ff @(posedge clock) begin
      product_ff <= neg_ff ? -$signed(mag_in) : $signed(mag_in);
   end

   assign product = product_ff;

endmodule

>>> src/wswh_log2.sv
// Pipelined log2: leading-one normalize, then one mantissa squaring per stage.
// No dependencies.
module wswh_log2 (
   input  logic        clock,
   input  logic [63:0] raw,
   output logic [5:0]  lead,
   output logic [31:0] frac
);

   localparam int STEPS = 32;

   logic [5:0]  pos_in;
   logic [63:0] norm_in;
   logic [31:0] m_ff [0:STEPS];
   logic [31:0] f_ff [0:STEPS];
   logic [5:0]  p_ff [0:STEPS];
   logic [31:0] m_in [1:STEPS];
   logic [31:0] f_in [1:STEPS];

   always_comb begin
      pos_in = '0;
      for (int i = 1; i < 64; i++) begin
         if (raw[i]) pos_in = 6'(i);
      end
      norm_in = raw << (6'd63 - pos_in);
   end

   always_comb begin
      logic [63:0] sq;
      for (int i = 1; i <= STEPS; i++) begin
         sq = 64'(m_ff[i-1]) * 64'(m_ff[i-1]);
         if (sq[63]) begin
            m_in[i] = sq[63:32];
            f_in[i] = f_ff[i-1] | (32'd1 << (STEPS - i));
         end else begin
            m_in[i] = sq[62:31];
            f_in[i] = f_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff[0] <= norm_in[63:32];
      f_ff[0] <= '0;
      p_ff[0] <= pos_in;
      for (int i = 1; i <= STEPS; i++) begin
         m_ff[i] <= m_in[i];
         f_ff[i] <= f_in[i];
         p_ff[i] <= p_ff[i-1];
      end
   end

   assign lead = p_ff[STEPS];
   assign frac = f_ff[STEPS];

endmodule

>>> src/wswh_exp.sv
// Pipelined exp of a Q32 value: scale to base 2, Taylor series on the fraction,
// round and saturate to the height format. Depends on wswh_pkg and wswh_mul.
module wswh_exp #(
   parameter int HEIGHT_FRAC_BITS = wswh_pkg::HEIGHT_FRAC_BITS
) (
   input  logic              clock,
   input  wswh_pkg::q32_type y,
   output logic [23:0]       height,
   output logic              saturated
);

   localparam int TERMS = 14;

   wswh_pkg::q32_type t;
   logic [63:0]        uprod;
   logic [31:0]        u_in;

   logic [31:0]        u_ff    [0:TERMS];
   logic signed [31:0] k_ff    [0:TERMS];
   logic [32:0]        term_ff [0:TERMS];
   logic [34:0]        sum_ff  [0:TERMS];
   logic [31:0]        prod_ff [1:TERMS];
   logic [31:0]        pu_ff   [1:TERMS];
   logic signed [31:0] pk_ff   [1:TERMS];
   logic [34:0]        psum_ff [1:TERMS];
   logic [31:0]        prod_in [1:TERMS];
   logic [31:0]        quot_in [1:TERMS];

   logic signed [33:0] kx, r_in;
   logic [5:0]         sh;
   logic [63:0]        v_in;
   logic               sat_in;
   logic [23:0]        height_ff;
   logic               saturated_ff;

   wswh_mul u_mul (.clock(clock), .op_a(y), .op_b(wswh_pkg::LOG2E_Q32), .product(t));

   assign uprod = 64'(t[31:0]) * 64'(wswh_pkg::LN2_Q32) + 64'h8000_0000;
   assign u_in  = uprod[63:32];

   always_comb begin
      logic [64:0] mp;
      logic [68:0] dq;
      for (int n = 1; n <= TERMS; n++) begin
         mp         = 65'(term_ff[n-1]) * 65'(u_ff[n-1]);
         prod_in[n] = mp[63:32];
         dq         = 69'(prod_ff[n]) * 69'(wswh_pkg::RECIP[n]);
         quot_in[n] = dq[67:36];
      end
   end

   always_ff @(posedge clock) begin
      u_ff[0]    <= u_in;
      k_ff[0]    <= t[63:32];
      term_ff[0] <= 33'h1_0000_0000;
      sum_ff[0]  <= 35'h1_0000_0000;
      for (int n = 1; n <= TERMS; n++) begin
         prod_ff[n] <= prod_in[n];
         pu_ff[n]   <= u_ff[n-1];
         pk_ff[n]   <= k_ff[n-1];
         psum_ff[n] <= sum_ff[n-1];
         term_ff[n] <= 33'(quot_in[n]);
         sum_ff[n]  <= psum_ff[n] + 35'(quot_in[n]);
         u_ff[n]    <= pu_ff[n];
         k_ff[n]    <= pk_ff[n];
      end
   end

   always_comb begin
      kx     = 34'(k_ff[TERMS]);
      r_in   = 34'(32 - HEIGHT_FRAC_BITS) - kx;
      sh     = r_in[5:0];
      sat_in = kx >= 34'(24 - HEIGHT_FRAC_BITS);
      if (r_in >= 34'sd64) begin
         v_in = '0;
      end else begin
         v_in = (64'(sum_ff[TERMS]) + (64'd1 << (sh - 6'd1))) >> sh;
      end
      if (v_in > 64'(wswh_pkg::HMAX)) sat_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      saturated_ff <= sat_in;
      height_ff    <= sat_in ? wswh_pkg::HMAX : v_in[23:0];
   end

   assign height    = height_ff;
   assign saturated = saturated_ff;

endmodule

>>> src/wind_sea_wave_height.sv
// Top level of the wind-sea significant wave height pipeline.
// Depends on wswh_pkg, wswh_dly, wswh_mul, wswh_log2 and wswh_exp.
//
//   channel   handshake          payload
//   request   start / busy       req_item  (wswh_pkg::req_type)
//   response  rsp_strobe         rsp_item  (wswh_pkg::rsp_type)
//
// One beat enters per cycle; rsp_strobe is high in the cycle its result is on rsp_item.
// Latency is set by the two 32-step log2 squaring chains, the polynomial
// multiply chain and the 14-term exp series, each multiply taking two stages.
// busy stays low: the pipeline never stalls and the receiver cannot stall it.
// Synchronous reset clears the valid chain only.
module wind_sea_wave_height #(
   parameter int HEIGHT_FRAC_BITS = wswh_pkg::HEIGHT_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wswh_pkg::req_type req_item,
   output logic              rsp_strobe,
   output wswh_pkg::rsp_type rsp_item
);

   localparam int ST_LOG = 34;
   localparam int ST_LM  = 36;
   localparam int ST_L   = 37;
   localparam int ST_Z4  = 48;
   localparam int ST_Y   = 51;
   localparam int ST_H   = 83;
   localparam int LAST   = 84;
   localparam int P_DELAY [4] = '{24, 26, 29, 32};

   logic vld_ff  [0:LAST];
   logic kind_ff [0:LAST];
   logic err_ff  [0:LAST];

   logic [15:0] speed_ff;
   logic [23:0] opnd_ff, opnd1_ff;
   logic [23:0] opnd_in;
   logic        err_in;
   wswh_pkg::q32_type s_ff;

   assign busy    = 1'b0;
   assign opnd_in = req_item.kind ? req_item.wind_duration : req_item.fetch_metres;
   assign err_in  = (req_item.wind_speed == 16'd0) || (opnd_in == 24'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int i = 1; i <= LAST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff[0] <= req_item.kind;
      err_ff[0]  <= err_in;
      for (int i = 1; i <= LAST; i++) begin
         kind_ff[i] <= kind_ff[i-1];
         err_ff[i]  <= err_ff[i-1];
      end
      speed_ff <= req_item.wind_speed;
      opnd_ff  <= opnd_in;
      opnd1_ff <= opnd_ff;
      s_ff     <= kind_ff[0] ? $signed({24'd0, speed_ff, 24'd0})
                             : $signed((64'(speed_ff) * wswh_pkg::KNOT_K + 64'd128) >> 8);
   end

   // Logs of speed and of fetch or duration.
   logic [5:0]  lead_s, lead_o;
   logic [31:0] frac_s, frac_o;
   logic signed [7:0] ip_s, ip_o;
   wswh_pkg::q32_type lg_s, lg_o, mls, mlo, l_ff, ls_ff;

   wswh_log2 u_log_s (.clock(clock), .raw(s_ff), .lead(lead_s), .frac(frac_s));
   wswh_log2 u_log_o (.clock(clock), .raw(64'(opnd1_ff)), .lead(lead_o), .frac(frac_o));

   assign ip_s = $signed({2'b00, lead_s}) - 8'sd32;
   assign ip_o = $signed({2'b00, lead_o}) - (kind_ff[ST_LOG] ? 8'sd8 : 8'sd0);
   assign lg_s = {{24{ip_s[7]}}, ip_s, frac_s};
   assign lg_o = {{24{ip_o[7]}}, ip_o, frac_o};

   wswh_mul u_mls (.clock(clock), .op_a(lg_s), .op_b(wswh_pkg::LN2_Q32), .product(mls));
   wswh_mul u_mlo (.clock(clock), .op_a(lg_o),
                   .op_b(kind_ff[ST_LOG] ? wswh_pkg::LOG10_2_Q32 : wswh_pkg::LN2_Q32),
                   .product(mlo));

   always_ff @(posedge clock) begin
      l_ff  <= kind_ff[ST_LM] ? mlo : mlo - wswh_pkg::THREE_LN10;
      ls_ff <= mls;
   end

   // Coefficient lanes: Horner in speed.
   wswh_pkg::q32_type hs [0:3];
   wswh_pkg::q32_type p_lane [4];

   assign hs[0] = s_ff;
   for (genvar j = 1; j < 4; j++) begin : g_hs
      wswh_dly #(.WIDTH(64), .DEPTH(3)) u_d (.clock(clock), .din(hs[j-1]), .dout(hs[j]));
   end

   for (genvar lane = 0; lane < 4; lane++) begin : g_lane
      wswh_pkg::q32_type acc0;
      wswh_pkg::q32_type acc_ff [1:4];
      wswh_pkg::q32_type hm [1:4];

      assign acc0 = kind_ff[1] ? wswh_pkg::COEF_DUR[lane][0] : wswh_pkg::COEF_FETCH[lane][0];

      wswh_mul u_h1 (.clock(clock), .op_a(acc0), .op_b(hs[0]), .product(hm[1]));
      for (genvar j = 2; j <= 4; j++) begin : g_step
         wswh_mul u_h (.clock(clock), .op_a(acc_ff[j-1]), .op_b(hs[j-1]), .product(hm[j]));
      end

      always_ff @(posedge clock) begin
         for (int j = 1; j <= 4; j++) begin
            acc_ff[j] <= hm[j] + (kind_ff[3*j] ? wswh_pkg::COEF_DUR[lane][j]
                                               : wswh_pkg::COEF_FETCH[lane][j]);
         end
      end

      wswh_dly #(.WIDTH(64), .DEPTH(P_DELAY[lane])) u_pd (
         .clock(clock), .din(acc_ff[4]), .dout(p_lane[lane]));
   end

   // Outer Horner in the fetch or duration log.
   wswh_pkg::q32_type l40, l43, l46, mc, mc48, m1, m2, m3, z4;
   wswh_pkg::q32_type z1_ff, z2_ff, z3_ff, e_ff, mez, e51, y;
   logic [23:0] h;
   logic        sat;
   wswh_pkg::rsp_type rsp_ff;

   wswh_dly #(.WIDTH(64), .DEPTH(3)) u_l40 (.clock(clock), .din(l_ff), .dout(l40));
   wswh_dly #(.WIDTH(64), .DEPTH(3)) u_l43 (.clock(clock), .din(l40), .dout(l43));
   wswh_dly #(.WIDTH(64), .DEPTH(3)) u_l46 (.clock(clock), .din(l43), .dout(l46));

   wswh_mul u_mc (.clock(clock),
                  .op_a(kind_ff[ST_L] ? wswh_pkg::C_DUR_S : wswh_pkg::C_FETCH_S),
                  .op_b(ls_ff), .product(mc));
   wswh_dly #(.WIDTH(64), .DEPTH(9)) u_mcd (.clock(clock), .din(mc), .dout(mc48));

   wswh_mul u_z1 (.clock(clock), .op_a(p_lane[0]), .op_b(l_ff), .product(m1));
   wswh_mul u_z2 (.clock(clock), .op_a(z1_ff), .op_b(l40), .product(m2));
   wswh_mul u_z3 (.clock(clock), .op_a(z2_ff), .op_b(l43), .product(m3));
   wswh_mul u_z4 (.clock(clock), .op_a(z3_ff), .op_b(l46), .product(z4));

   always_ff @(posedge clock) begin
      z1_ff <= m1 + p_lane[1];
      z2_ff <= m2 + p_lane[2];
      z3_ff <= m3 + p_lane[3];
      e_ff  <= z4 + mc48 - (kind_ff[ST_Z4] ? wswh_pkg::C_DUR_K : wswh_pkg::C_FETCH_K);
   end

   wswh_mul u_ez (.clock(clock), .op_a(e_ff), .op_b(wswh_pkg::LN10_Q32), .product(mez));
   wswh_dly #(.WIDTH(64), .DEPTH(2)) u_ed (.clock(clock), .din(e_ff), .dout(e51));

   assign y = kind_ff[ST_Y] ? mez : e51;

   wswh_exp #(.HEIGHT_FRAC_BITS(HEIGHT_FRAC_BITS)) u_exp (
      .clock(clock), .y(y), .height(h), .saturated(sat));

   always_ff @(posedge clock) begin
      if (err_ff[ST_H]) begin
         rsp_ff.wave_height <= '0;
         rsp_ff.status      <= wswh_pkg::STATUS_DOMAIN;
      end else begin
         rsp_ff.wave_height <= h;
         rsp_ff.status      <= sat ? wswh_pkg::STATUS_SAT : wswh_pkg::STATUS_OK;
      end
   end

   assign rsp_strobe = vld_ff[LAST];
   assign rsp_item   = rsp_ff;

endmodule

>>> verif/wind_sea_wave_height_tb.sv
// Self-checking testbench for wind_sea_wave_height: a directed table, then random beats.
// Each beat's height and status are predicted in fixed point and compared with the DUT.
// Depends on wswh_pkg and the wind_sea_wave_height RTL.
module wind_sea_wave_height_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      wswh_pkg::req_type    item;
      logic                 known;
      logic [23:0]          height;
      wswh_pkg::status_type status;
   } row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   wswh_pkg::req_type req_item;
   logic              rsp_strobe;
   wswh_pkg::rsp_type rsp_item;

   wswh_pkg::rsp_type expected_heights[$];
   int      errors;
   int      beats_sent;
   int      heights_checked;
   int      domain_seen;
   int      sat_seen;
   longint  cycle_count;

   wind_sea_wave_height DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint fix_mul(longint a, longint b);
      logic [127:0] pa, pb, prod;
      logic [127:0] m;
      logic         neg;
      neg = (a < 0) != (b < 0);
      pa = (a < 0) ? 128'(-a) : 128'(a);
      pb = (b < 0) ? 128'(-b) : 128'(b);
      if ((pa[63:32] * pb[63:32]) >= (128'd1 << 28) || (pa[31:0] * pb[63:32]) >= (128'd1 << 61)
          || (pa[63:32] * pb[31:0]) >= (128'd1 << 61)) begin
         m = 128'd1 << 60;
      end else begin
         prod = pa * pb;
         m = (prod + 128'h8000_0000) >> 32;
         if (m > (128'd1 << 60)) m = 128'd1 << 60;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint poly_eval(input wswh_pkg::q32_type c[5], int first, longint x);
      longint acc;
      acc = c[first];
      for (int i = first + 1; i < 5; i++) acc = fix_mul(acc, x) + c[i];
      return acc;
   endfunction

   function automatic longint log2_fix(logic [63:0] raw, int fbits);
      int          p;
      logic [63:0] m, frac;
      p = 63;
      frac = '0;
      while (p > 0 && raw[p] == 1'b0) p--;
      m = (p <= 31) ? raw << (31 - p) : raw >> (p - 31);
      for (int i = 1; i <= 32; i++) begin
         m = (m * m) >> 31;
         if (m >= wswh_pkg::TWO32) begin
            m = m >> 1;
            frac[32 - i] = 1'b1;
         end
      end
      return longint'(p - fbits) * 64'sd4294967296 + longint'(frac);
   endfunction

   function automatic wswh_pkg::rsp_type exp_to_height(longint y);
      wswh_pkg::rsp_type r;
      longint      t, k, f;
      logic [63:0] u, term, sum, v;
      int          sh;
      t = fix_mul(y, wswh_pkg::LOG2E_Q32);
      k = t >>> 32;
      f = t - k * 64'sd4294967296;
      u = fix_mul(f, wswh_pkg::LN2_Q32);
      term = wswh_pkg::TWO32;
      sum = wswh_pkg::TWO32;
      for (int n = 1; n <= 14; n++) begin
         term = 64'(((128'(term) * u) >> 32) / n);
         sum += term;
      end
      r.status = wswh_pkg::STATUS_OK;
      r.wave_height = '0;
      if (k + wswh_pkg::HEIGHT_FRAC_BITS >= 24) begin
         r.status = wswh_pkg::STATUS_SAT;
         r.wave_height = wswh_pkg::HMAX;
         return r;
      end
      sh = 32 - wswh_pkg::HEIGHT_FRAC_BITS - int'(k);
      if (sh >= 64) return r;
      v = 64'((65'(sum) + (65'd1 << (sh - 1))) >> sh);
      if (v > 64'(wswh_pkg::HMAX)) begin
         r.status = wswh_pkg::STATUS_SAT;
         r.wave_height = wswh_pkg::HMAX;
      end else begin
         r.wave_height = v[23:0];
      end
      return r;
   endfunction

   function automatic wswh_pkg::rsp_type predict_height(wswh_pkg::req_type q);
      wswh_pkg::rsp_type r;
      longint      s, ls, lf, ld, a, b, e, z;
      logic [63:0] sp;
      sp = 64'(q.wind_speed);
      if (q.wind_speed == 0 || (!q.kind && q.fetch_metres == 0)
          || (q.kind && q.wind_duration == 0)) begin
         r.wave_height = '0;
         r.status = wswh_pkg::STATUS_DOMAIN;
         return r;
      end
      if (!q.kind) begin
         s = longint'((sp * wswh_pkg::KNOT_K + 64'd128) >> 8);
         ls = fix_mul(log2_fix(s, 32), wswh_pkg::LN2_Q32);
         lf = fix_mul(log2_fix(64'(q.fetch_metres), 0), wswh_pkg::LN2_Q32)
              - wswh_pkg::THREE_LN10;
         a = poly_eval(wswh_pkg::COEF_FETCH[2], 0, s);
         b = poly_eval(wswh_pkg::COEF_FETCH[3], 0, s);
         e = fix_mul(fix_mul(a, lf) + b, lf) + fix_mul(wswh_pkg::C_FETCH_S, ls)
             - wswh_pkg::C_FETCH_K;
         r = exp_to_height(e);
      end else begin
         s = longint'(sp << 24);
         ls = fix_mul(log2_fix(s, 32), wswh_pkg::LN2_Q32);
         ld = fix_mul(log2_fix(64'(q.wind_duration), 8), wswh_pkg::LOG10_2_Q32);
         z = fix_mul(poly_eval(wswh_pkg::COEF_DUR[0], 2, s), ld)
             + poly_eval(wswh_pkg::COEF_DUR[1], 2, s);
         z = fix_mul(z, ld) + poly_eval(wswh_pkg::COEF_DUR[2], 1, s);
         z = fix_mul(z, ld) + poly_eval(wswh_pkg::COEF_DUR[3], 0, s);
         z = fix_mul(z, ld) + fix_mul(wswh_pkg::C_DUR_S, ls) - wswh_pkg::C_DUR_K;
         r = exp_to_height(fix_mul(z, wswh_pkg::LN10_Q32));
      end
      return r;
   endfunction

   task automatic send_beat(wswh_pkg::req_type q, logic idle_ok);
      if (idle_ok) begin
         while ($urandom_range(99) < 29) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_item <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_heights.push_back(predict_height(q));
      beats_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         wswh_pkg::rsp_type want;
         if (expected_heights.size() == 0) begin
            $error("unexpected result height=%h status=%0d", rsp_item.wave_height, rsp_item.status);
            errors++;
         end else begin
            want = expected_heights.pop_front();
            if (rsp_item.wave_height !== want.wave_height) begin
               $error("wave_height expected %h actual %h", want.wave_height, rsp_item.wave_height);
               errors++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_item.status);
               errors++;
            end
            if (want.status == wswh_pkg::STATUS_DOMAIN) domain_seen++;
            if (want.status == wswh_pkg::STATUS_SAT) sat_seen++;
            heights_checked++;
         end
      end
   end

   initial begin
      wait (cycle_count > 2000000);
      $display("wind_sea_wave_height regression: fail");
      $finish;
   end

   initial begin
      row_type rows[$];
      row_type row;
      wswh_pkg::req_type q;
      int      drain;
      errors = 0;
      beats_sent = 0;
      heights_checked = 0;
      domain_seen = 0;
      sat_seen = 0;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows.push_back('{'{1'b0, 16'h0000, 24'h000100, 24'h000000}, 1'b1, 24'h0,
                       wswh_pkg::STATUS_DOMAIN});
      rows.push_back('{'{1'b1, 16'h0000, 24'h000000, 24'h000100}, 1'b1, 24'h0,
                       wswh_pkg::STATUS_DOMAIN});
      rows.push_back('{'{1'b0, 16'h0A00, 24'h000000, 24'hFFFFFF}, 1'b1, 24'h0,
                       wswh_pkg::STATUS_DOMAIN});
      rows.push_back('{'{1'b1, 16'h0A00, 24'hFFFFFF, 24'h000000}, 1'b1, 24'h0,
                       wswh_pkg::STATUS_DOMAIN});
      rows.push_back('{'{1'b0, 16'h0000, 24'h000000, 24'h000000}, 1'b1, 24'h0,
                       wswh_pkg::STATUS_DOMAIN});
      rows.push_back('{'{1'b0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b0, 16'h0001, 24'h000001, 24'h000000}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b1, 16'h0001, 24'h000000, 24'h000001}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b0, 16'h0A00, 24'h00C350, 24'h000000}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b1, 16'h0A00, 24'h000000, 24'h000C00}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b0, 16'h1400, 24'h0F4240, 24'hABCDEF}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b1, 16'h1400, 24'h123456, 24'h00FFFF}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b0, 16'h8000, 24'h000001, 24'h000000}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b1, 16'h0100, 24'h000000, 24'h800000}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});
      rows.push_back('{'{1'b1, 16'h0080, 24'h000000, 24'h000080}, 1'b0, 24'h0,
                       wswh_pkg::STATUS_OK});

      foreach (rows[i]) begin
         row = rows[i];
         if (row.known) begin
            q = row.item;
            if (predict_height(q) !== wswh_pkg::rsp_type'({row.height, row.status})) begin
               $error("directed row %0d: table and predictor disagree", i);
               errors++;
            end
         end
         send_beat(row.item, 1'b0);
      end

      for (int n = 0; n < 1100; n++) begin
         q.kind = 1'($urandom_range(1));
         case ($urandom_range(9))
            0: q.wind_speed = 16'($urandom_range(3));
            1: q.wind_speed = 16'($urandom);
            default: q.wind_speed = 16'($urandom_range(16'h4000, 16'h0080));
         endcase
         q.fetch_metres = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(24'h100000));
         q.wind_duration = ($urandom_range(9) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(24'h040000));
         if ($urandom_range(49) == 0) q.fetch_metres = '0;
         if ($urandom_range(49) == 0) q.wind_duration = '0;
         send_beat(q, !(n >= 400 && n < 600));
      end
      start <= 1'b0;

      drain = 0;
      while (expected_heights.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (100) @(posedge clock);
      if (expected_heights.size() != 0) begin
         $error("%0d results never arrived", expected_heights.size());
         errors++;
      end

      $display("%0d beats driven, %0d heights checked (fetch and duration modes)",
               beats_sent, heights_checked);
      $display("%0d domain errors and %0d saturations among them", domain_seen, sat_seen);
      if (errors == 0) begin
         $display("wind_sea_wave_height regression: pass");
      end else begin
         $display("wind_sea_wave_height regression: fail");
      end
      $finish;
   end
endmodule
